// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the cycle after the antecedent, skip while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Check the consequent in the cycle after the antecedent, reset included.
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/irg_pkg.sv
package irg_pkg;

    localparam int SIZE_LOG = 8;
    localparam int SIZE     = 1 << SIZE_LOG;
    localparam int AW       = SIZE_LOG;
    localparam int CNT_W    = SIZE_LOG + 1;
    localparam int HALF     = SIZE / 2;
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_SEEDED   = 2'd1;
    localparam logic [1:0] MODE_UNSEEDED = 2'd2;
    localparam logic [1:0] MODE_DRAW     = 2'd3;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] vec_t;

    // One line of the eight-word scramble.
    function automatic vec_t scramble_line(vec_t v, logic [2:0] j);
        vec_t        r;
        logic [2:0]  j1;
        logic [2:0]  j2;
        logic [2:0]  j3;
        word_t       sh;
        r  = v;
        j1 = j + 3'd1;
        j2 = j + 3'd2;
        j3 = j + 3'd3;
        case (j)
            3'd0:    sh = v[j1] << 11;
            3'd1:    sh = v[j1] >> 2;
            3'd2:    sh = v[j1] << 8;
            3'd3:    sh = v[j1] >> 16;
            3'd4:    sh = v[j1] << 10;
            3'd5:    sh = v[j1] >> 4;
            3'd6:    sh = v[j1] << 8;
            default: sh = v[j1] >> 9;
        endcase
        r[j]  = v[j] ^ sh;
        r[j3] = v[j3] + r[j];
        r[j1] = v[j1] + v[j2];
        return r;
    endfunction

endpackage

// File: rtl/core/irg_ram.sv
module irg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/isaac_random_generator.sv
// ISAAC 32-bit random generator. tuser selects the transaction kind: 0 loads a
// seed word into the result buffer, 1 and 2 initialise with or without seed, 3
// draws one word, the only kind that returns a result. After reset a clearing
// pass zeroes both memories before the first input is taken. When words are
// left a draw reads the result buffer; otherwise it first runs a round over the
// single read port of the mixing memory, through states RX, RH, RA, RY, RB and
// RBW for each word. Initialisation scrambles the eight-word state four times,
// then per 8-word group adds seed words (seeded only), scrambles once and writes
// the eight words, once or twice over the memory, and then runs one round.
module isaac_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic [39:0] s_tdata,   // [7:0] seed_index, [39:8] seed_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_value
);

    localparam int AW = irg_pkg::AW;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SCR    = 4'd2;
    localparam logic [3:0] ST_FRD    = 4'd3;
    localparam logic [3:0] ST_FADD   = 4'd4;
    localparam logic [3:0] ST_FWR    = 4'd5;
    localparam logic [3:0] ST_RSTART = 4'd6;
    localparam logic [3:0] ST_RX     = 4'd7;
    localparam logic [3:0] ST_RH     = 4'd8;
    localparam logic [3:0] ST_RA     = 4'd9;
    localparam logic [3:0] ST_RY     = 4'd10;
    localparam logic [3:0] ST_RB     = 4'd11;
    localparam logic [3:0] ST_RBW    = 4'd12;
    localparam logic [3:0] ST_DRD    = 4'd13;
    localparam logic [3:0] ST_DOUT   = 4'd14;

    logic [3:0]                  state_reg, state_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [2:0]                  k_reg, k_next;
    logic [2:0]                  line_reg, line_next;
    logic [1:0]                  rep_reg, rep_next;
    logic                        pre_reg, pre_next;
    logic                        seeded_reg, seeded_next;
    logic                        pass_reg, pass_next;
    logic                        init_call_reg, init_call_next;
    logic [irg_pkg::CNT_W-1:0]   wl_reg, wl_next;
    irg_pkg::word_t              a_reg, a_next;
    irg_pkg::word_t              b_reg, b_next;
    irg_pkg::word_t              rc_reg, rc_next;
    irg_pkg::word_t              x_reg, x_next;
    irg_pkg::word_t              y_reg, y_next;
    irg_pkg::vec_t               v_reg, v_next;
    logic                        out_valid_reg, out_valid_next;
    irg_pkg::word_t              out_data_reg, out_data_next;

    logic           mm_we, rb_we;
    logic [AW-1:0]  mm_waddr, rb_waddr, mm_raddr, rb_raddr;
    irg_pkg::word_t mm_wdata, rb_wdata, mm_q, rb_q;

    logic [AW-1:0]  fill_addr;
    logic [AW+7:0]  seed_wide;
    irg_pkg::word_t mixed;
    logic           accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign fill_addr = idx_reg | AW'(k_reg);
    assign seed_wide = {AW'(0), s_tdata[7:0]};

    always_comb begin
        case (idx_reg[1:0])
            2'd0:    mixed = a_reg << 13;
            2'd1:    mixed = a_reg >> 6;
            2'd2:    mixed = a_reg << 2;
            default: mixed = a_reg >> 16;
        endcase
    end

    irg_ram #(.WIDTH(32), .DEPTH(irg_pkg::SIZE)) u_mix_mem (
        .aclk  (aclk),
        .we    (mm_we),
        .waddr (mm_waddr),
        .wdata (mm_wdata),
        .raddr (mm_raddr),
        .rdata (mm_q)
    );

    irg_ram #(.WIDTH(32), .DEPTH(irg_pkg::SIZE)) u_result_mem (
        .aclk  (aclk),
        .we    (rb_we),
        .waddr (rb_waddr),
        .wdata (rb_wdata),
        .raddr (rb_raddr),
        .rdata (rb_q)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        line_next      = line_reg;
        rep_next       = rep_reg;
        pre_next       = pre_reg;
        seeded_next    = seeded_reg;
        pass_next      = pass_reg;
        init_call_next = init_call_reg;
        wl_next        = wl_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rc_next        = rc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        v_next         = v_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        mm_we    = 1'b0;
        mm_waddr = idx_reg;
        mm_wdata = '0;
        mm_raddr = idx_reg;
        rb_we    = 1'b0;
        rb_waddr = idx_reg;
        rb_wdata = '0;
        rb_raddr = wl_reg[AW-1:0];

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                mm_we = 1'b1;
                rb_we = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(irg_pkg::SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        irg_pkg::MODE_LOAD: begin
                            rb_we    = 1'b1;
                            rb_waddr = seed_wide[AW-1:0];
                            rb_wdata = s_tdata[39:8];
                        end
                        irg_pkg::MODE_DRAW: begin
                            if (wl_reg == '0) begin
                                wl_next        = irg_pkg::CNT_W'(irg_pkg::SIZE - 1);
                                init_call_next = 1'b0;
                                state_next     = ST_RSTART;
                            end else begin
                                wl_next    = wl_reg - irg_pkg::CNT_W'(1);
                                state_next = ST_DRD;
                            end
                        end
                        default: begin
                            a_next      = '0;
                            b_next      = '0;
                            rc_next     = '0;
                            v_next      = {8{irg_pkg::GOLDEN}};
                            rep_next    = 2'd0;
                            line_next   = 3'd0;
                            pre_next    = 1'b1;
                            seeded_next = (s_tuser == irg_pkg::MODE_SEEDED);
                            pass_next   = 1'b0;
                            idx_next    = '0;
                            k_next      = 3'd0;
                            state_next  = ST_SCR;
                        end
                    endcase
                end
            end
            ST_SCR: begin
                v_next    = irg_pkg::scramble_line(v_reg, line_reg);
                line_next = line_reg + 3'd1;
                if (line_reg == 3'd7) begin
                    if (pre_reg) begin
                        rep_next = rep_reg + 2'd1;
                        if (rep_reg == 2'd3) begin
                            pre_next   = 1'b0;
                            state_next = seeded_reg ? ST_FRD : ST_SCR;
                        end
                    end else begin
                        state_next = ST_FWR;
                    end
                end
            end
            ST_FRD: begin
                rb_raddr   = fill_addr;
                mm_raddr   = fill_addr;
                state_next = ST_FADD;
            end
            ST_FADD: begin
                v_next[k_reg] = v_reg[k_reg] + (pass_reg ? mm_q : rb_q);
                k_next        = k_reg + 3'd1;
                state_next    = (k_reg == 3'd7) ? ST_SCR : ST_FRD;
            end
            ST_FWR: begin
                mm_we    = 1'b1;
                mm_waddr = fill_addr;
                mm_wdata = v_reg[k_reg];
                k_next   = k_reg + 3'd1;
                if (k_reg == 3'd7) begin
                    idx_next = idx_reg + AW'(8);
                    if (idx_reg == AW'(irg_pkg::SIZE - 8)) begin
                        if (seeded_reg && !pass_reg) begin
                            pass_next  = 1'b1;
                            state_next = ST_FRD;
                        end else begin
                            init_call_next = 1'b1;
                            state_next     = ST_RSTART;
                        end
                    end else begin
                        state_next = seeded_reg ? ST_FRD : ST_SCR;
                    end
                end
            end
            ST_RSTART: begin
                rc_next    = rc_reg + 32'd1;
                b_next     = b_reg + rc_reg + 32'd1;
                idx_next   = '0;
                state_next = ST_RX;
            end
            ST_RX: begin
                mm_raddr   = idx_reg;
                state_next = ST_RH;
            end
            ST_RH: begin
                x_next     = mm_q;
                mm_raddr   = idx_reg + AW'(irg_pkg::HALF);
                state_next = ST_RA;
            end
            ST_RA: begin
                a_next     = (a_reg ^ mixed) + mm_q;
                mm_raddr   = x_reg[AW+1:2];
                state_next = ST_RY;
            end
            ST_RY: begin
                y_next     = mm_q + a_reg + b_reg;
                mm_we      = 1'b1;
                mm_waddr   = idx_reg;
                mm_wdata   = y_next;
                state_next = ST_RB;
            end
            ST_RB: begin
                // read after the write of this word has landed
                mm_raddr   = y_reg[irg_pkg::SIZE_LOG+2+AW-1:irg_pkg::SIZE_LOG+2];
                state_next = ST_RBW;
            end
            ST_RBW: begin
                b_next   = mm_q + x_reg;
                rb_we    = 1'b1;
                rb_waddr = idx_reg;
                rb_wdata = b_next;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(irg_pkg::SIZE - 1)) begin
                    if (init_call_reg) begin
                        wl_next    = irg_pkg::CNT_W'(irg_pkg::SIZE);
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DRD;
                    end
                end else begin
                    state_next = ST_RX;
                end
            end
            ST_DRD: begin
                state_next = ST_DOUT;
            end
            ST_DOUT: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = rb_q;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            k_reg         <= 3'd0;
            line_reg      <= 3'd0;
            rep_reg       <= 2'd0;
            pre_reg       <= 1'b0;
            seeded_reg    <= 1'b0;
            pass_reg      <= 1'b0;
            init_call_reg <= 1'b0;
            wl_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            line_reg      <= line_next;
            rep_reg       <= rep_next;
            pre_reg       <= pre_next;
            seeded_reg    <= seeded_next;
            pass_reg      <= pass_next;
            init_call_reg <= init_call_next;
            wl_reg        <= wl_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            rc_reg        <= rc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/irg_checker.sv
`include "assert_macros.svh"

module irg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Reset drops any pending result.
    `ASSERT_ALWAYS_NEXT(a_reset_out, aclk, !aresetn, !m_tvalid)
    // The clearing pass keeps the input closed right after reset.
    `ASSERT_ALWAYS_NEXT(a_reset_busy, aclk, !aresetn, !s_tready)
    // Draws and initialisations keep the input closed in the cycle after acceptance.
    `ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser != irg_pkg::MODE_LOAD, !s_tready)
    // After a seed load the input is open again in the next cycle.
    `ASSERT_NEXT(a_load_fast, aclk, aresetn, s_tvalid && s_tready && s_tuser == irg_pkg::MODE_LOAD, s_tready)

endmodule

bind isaac_random_generator irg_checker u_irg_checker (.*);
